// ===== sv/hbd_pkg.sv =====
// Shared types, widths and codes for the Huffman tree build and decode block.
package hbd_pkg;

  localparam int MAX_SYMBOLS = 256;
  localparam int TREE_SLOTS  = 512;
  localparam int SYM_W       = $clog2(MAX_SYMBOLS);
  localparam int SLOT_W      = $clog2(TREE_SLOTS);
  localparam int FREE_W      = SLOT_W + 1;
  localparam int DIM_W       = 15;
  localparam int CNT_W       = 2 * DIM_W;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_LEAF = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // Write request into the leaf locator; a write always marks the entry valid.
  typedef struct packed {
    logic  en;
    sym_t  sym;
    slot_t slot;
  } loc_wr_t;

  // What a node keeps about one of its children.
  typedef struct packed {
    slot_t slot;
    logic  internal;
    sym_t  sym;
  } child_t;

  // Back link from a node to its parent and the side it hangs on.
  typedef struct packed {
    slot_t slot;
    logic  right_side;
  } parent_t;

endpackage

// ===== sv/hbd_leaf_locator.sv =====
// Leaf locator: per-symbol valid flags and slot memory of the leaf that holds each symbol.
module hbd_leaf_locator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  hbd_pkg::sym_t       rd_sym_i,
  output hbd_pkg::slot_t      rd_slot_o,
  input  hbd_pkg::sym_t       query_sym_i,
  output logic                query_valid_o,
  input  hbd_pkg::loc_wr_t    wr_i
);

  logic [hbd_pkg::MAX_SYMBOLS-1:0] valid_q;
  hbd_pkg::slot_t                  slot_mem [hbd_pkg::MAX_SYMBOLS];
  hbd_pkg::slot_t                  rd_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.sym] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      slot_mem[wr_i.sym] <= wr_i.slot;
    end
    rd_slot_q <= slot_mem[rd_sym_i];
  end

  assign rd_slot_o     = rd_slot_q;
  assign query_valid_o = valid_q[query_sym_i];

endmodule

// ===== sv/huffman_tree_build_and_decode.sv =====
// Top level: Huffman tree builder and bit-serial tree-walk pixel decoder.
//
// Requests enter on start_i while busy_o is low; every request gives one or more
// results, each shown for exactly one cycle with result_valid_o high, and the
// receiver cannot stall them. A clear or unknown operation passes through the end
// state only, a merge-pair load through both load states and the end state (the
// first load state and the end state when the load is refused), and a code byte
// through the decode state once per bit and then the end state: the byte sits in a
// shift register and one bit leaves it per cycle, each bit being one step down the
// tree, with the node store read once per step (the next node address feeds the
// registered read directly). A new request is taken only once the block is back in
// idle. Each result is held back until the next result of the same request is
// found or the request ends, and the final result of a request (last_result_o)
// comes out as busy_o falls. Merge pairs go in from the last merge to the first.
// Node slots are handed out in order, so a slot at or above the fill mark counts as
// empty: no clearing pass is needed after reset or a clear. width*height is formed
// in a register from the registered width and height after a configuration write.
module huffman_tree_build_and_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [hbd_pkg::DIM_W-1:0] cfg_wdata_i,
  // request
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                operation_i,
  input  logic [7:0]                left_symbol_i,
  input  logic [7:0]                right_symbol_i,
  input  logic [7:0]                code_byte_i,
  // results
  output logic                      result_valid_o,
  output logic [1:0]                status_o,
  output logic [7:0]                pixel_value_o,
  output logic                      pixel_valid_o,
  output logic                      last_result_o,
  output logic                      image_done_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD1,
    S_LD2,
    S_DEC,
    S_END
  } state_e;

  state_e                      state_q;
  logic [hbd_pkg::DIM_W-1:0]   width_q, height_q;
  logic [hbd_pkg::CNT_W-1:0]   target_q;
  logic [hbd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [hbd_pkg::FREE_W-1:0]  next_free_q;
  logic                        root_has_q;
  hbd_pkg::slot_t              walk_q, walk_d;
  logic [7:0]                  sh_q;
  logic [2:0]                  bit_cnt_q;
  hbd_pkg::sym_t               ls_q, rs_q;
  hbd_pkg::slot_t              p_q;

  // one result held back until we know whether another follows it
  logic                        pend_v_q;
  logic [1:0]                  pend_status_q;
  hbd_pkg::sym_t               pend_pix_q;
  logic                        pend_pv_q;

  logic                        res_valid_q, pix_valid_q, last_q, done_q;
  logic [1:0]                  status_q;
  hbd_pkg::sym_t               pix_q;

  // node store: one child record per side, and a back link per node
  hbd_pkg::child_t             left_mem  [hbd_pkg::TREE_SLOTS];
  hbd_pkg::child_t             right_mem [hbd_pkg::TREE_SLOTS];
  hbd_pkg::parent_t            par_mem   [hbd_pkg::TREE_SLOTS];
  hbd_pkg::child_t             ldesc_q, rdesc_q;
  hbd_pkg::parent_t            par_rd_q;

  logic                        lwe, rwe, pwe;
  hbd_pkg::slot_t              laddr, raddr, paddr, rd_addr;
  hbd_pkg::child_t             lwdata, rwdata;
  hbd_pkg::parent_t            pwdata;

  hbd_pkg::loc_wr_t            loc_wr;
  hbd_pkg::slot_t              loc_rd_slot;
  hbd_pkg::sym_t               loc_query_sym;
  logic                        loc_query_valid;

  logic                        accept, done_now, loc_clear;
  logic                        tree_full, ld_ok;
  logic [1:0]                  ld_status;
  hbd_pkg::slot_t              slot_p, slot_a, slot_b;
  hbd_pkg::child_t             sel;
  logic                        step_res, step_pv;
  logic [1:0]                  step_status;
  hbd_pkg::sym_t               step_pix;

  assign accept    = start_i && (state_q == S_IDLE);
  assign busy_o    = (state_q != S_IDLE);
  assign done_now  = (cnt_q >= target_q);
  assign loc_clear = accept && (operation_i == hbd_pkg::OP_CLEAR);

  hbd_leaf_locator u_locator (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (loc_clear),
    .rd_sym_i      (left_symbol_i),
    .rd_slot_o     (loc_rd_slot),
    .query_sym_i   (loc_query_sym),
    .query_valid_o (loc_query_valid),
    .wr_i          (loc_wr)
  );

  assign loc_query_sym = (state_q == S_LD2) ? rs_q : ls_q;

  // Load checks: left symbol must sit on a leaf once the root has children,
  // and two free slots must remain.
  assign tree_full = (next_free_q > hbd_pkg::FREE_W'(hbd_pkg::TREE_SLOTS - 2));
  assign slot_p    = root_has_q ? loc_rd_slot : '0;
  assign slot_a    = next_free_q[hbd_pkg::SLOT_W-1:0];
  assign slot_b    = slot_a + hbd_pkg::SLOT_W'(1);

  always_comb begin
    ld_ok     = 1'b1;
    ld_status = hbd_pkg::STATUS_OK;
    if (root_has_q && !loc_query_valid) begin
      ld_ok     = 1'b0;
      ld_status = hbd_pkg::STATUS_NOT_LEAF;
    end else if (tree_full) begin
      ld_ok     = 1'b0;
      ld_status = hbd_pkg::STATUS_FULL;
    end
  end

  // Tree writes. First load cycle hangs the two new leaves under the parent and
  // links the left leaf back; the second links the right leaf back and flags the
  // old leaf as internal in its own parent's record.
  always_comb begin
    lwe    = 1'b0;
    rwe    = 1'b0;
    pwe    = 1'b0;
    laddr  = slot_p;
    raddr  = slot_p;
    paddr  = slot_a;
    lwdata = '{slot: slot_a, internal: 1'b0, sym: ls_q};
    rwdata = '{slot: slot_b, internal: 1'b0, sym: rs_q};
    pwdata = '{slot: slot_p, right_side: 1'b0};
    loc_wr = '{en: 1'b0, sym: ls_q, slot: slot_a};
    case (state_q)
      S_LD1: begin
        if (ld_ok) begin
          lwe    = 1'b1;
          rwe    = 1'b1;
          pwe    = 1'b1;
          loc_wr = '{en: 1'b1, sym: ls_q, slot: slot_a};
        end
      end
      S_LD2: begin
        pwe    = 1'b1;
        paddr  = slot_b;
        pwdata = '{slot: p_q, right_side: 1'b1};
        loc_wr = '{en: !loc_query_valid, sym: rs_q, slot: slot_b};
        if (root_has_q) begin
          laddr  = par_rd_q.slot;
          raddr  = par_rd_q.slot;
          lwdata = '{slot: p_q, internal: 1'b1, sym: '0};
          rwdata = '{slot: p_q, internal: 1'b1, sym: '0};
          lwe    = !par_rd_q.right_side;
          rwe    = par_rd_q.right_side;
        end
      end
      default: begin
      end
    endcase
  end

  // One tree step per code bit: pick the child record, then go down,
  // emit a pixel, or flag an empty node.
  assign sel = sh_q[0] ? rdesc_q : ldesc_q;

  always_comb begin
    step_res    = 1'b0;
    step_status = hbd_pkg::STATUS_OK;
    step_pix    = '0;
    step_pv     = 1'b0;
    walk_d      = walk_q;
    cnt_d       = cnt_q;
    if (state_q == S_DEC && !done_now) begin
      if (walk_q == '0 && !root_has_q) begin
        step_res    = 1'b1;
        step_status = hbd_pkg::STATUS_EMPTY;
        walk_d      = '0;
      end else if ({1'b0, sel.slot} >= next_free_q) begin
        step_res    = 1'b1;
        step_status = hbd_pkg::STATUS_EMPTY;
        walk_d      = '0;
      end else if (sel.internal) begin
        walk_d = sel.slot;
      end else begin
        step_res = 1'b1;
        step_pv  = 1'b1;
        step_pix = sel.sym;
        walk_d   = '0;
        cnt_d    = cnt_q + hbd_pkg::CNT_W'(1);
      end
    end
  end

  // Read the next node in the same cycle its address is known.
  assign rd_addr = (state_q == S_DEC) ? walk_d : walk_q;

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      left_mem[laddr] <= lwdata;
    end
    if (rwe) begin
      right_mem[raddr] <= rwdata;
    end
    if (pwe) begin
      par_mem[paddr] <= pwdata;
    end
    ldesc_q  <= left_mem[rd_addr];
    rdesc_q  <= right_mem[rd_addr];
    par_rd_q <= par_mem[slot_p];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      width_q       <= hbd_pkg::DIM_W'(1);
      height_q      <= hbd_pkg::DIM_W'(1);
      target_q      <= hbd_pkg::CNT_W'(1);
      cnt_q         <= '0;
      next_free_q   <= hbd_pkg::FREE_W'(1);
      root_has_q    <= 1'b0;
      walk_q        <= '0;
      sh_q          <= '0;
      bit_cnt_q     <= '0;
      ls_q          <= '0;
      rs_q          <= '0;
      p_q           <= '0;
      pend_v_q      <= 1'b0;
      pend_status_q <= hbd_pkg::STATUS_OK;
      pend_pix_q    <= '0;
      pend_pv_q     <= 1'b0;
      res_valid_q   <= 1'b0;
      status_q      <= hbd_pkg::STATUS_OK;
      pix_q         <= '0;
      pix_valid_q   <= 1'b0;
      last_q        <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      target_q    <= width_q * height_q;

      if (cfg_we_i) begin
        case (cfg_index_i)
          hbd_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
          hbd_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ls_q      <= left_symbol_i;
            rs_q      <= right_symbol_i;
            sh_q      <= code_byte_i;
            bit_cnt_q <= '0;
            case (operation_i)
              hbd_pkg::OP_CLEAR: begin
                next_free_q <= hbd_pkg::FREE_W'(1);
                root_has_q  <= 1'b0;
                walk_q      <= '0;
                cnt_q       <= '0;
                state_q     <= S_END;
              end
              hbd_pkg::OP_LOAD:   state_q <= S_LD1;
              hbd_pkg::OP_DECODE: state_q <= S_DEC;
              default:            state_q <= S_END;
            endcase
          end
        end
        S_LD1: begin
          if (ld_ok) begin
            p_q     <= slot_p;
            state_q <= S_LD2;
          end else begin
            pend_v_q      <= 1'b1;
            pend_status_q <= ld_status;
            pend_pix_q    <= '0;
            pend_pv_q     <= 1'b0;
            state_q       <= S_END;
          end
        end
        S_LD2: begin
          next_free_q   <= next_free_q + hbd_pkg::FREE_W'(2);
          root_has_q    <= 1'b1;
          pend_v_q      <= 1'b1;
          pend_status_q <= hbd_pkg::STATUS_OK;
          pend_pix_q    <= '0;
          pend_pv_q     <= 1'b0;
          state_q       <= S_END;
        end
        S_DEC: begin
          walk_q    <= walk_d;
          cnt_q     <= cnt_d;
          sh_q      <= {1'b0, sh_q[7:1]};
          bit_cnt_q <= bit_cnt_q + 3'd1;
          if (step_res) begin
            // a newer result exists, so the held one is not the last
            if (pend_v_q) begin
              res_valid_q <= 1'b1;
              status_q    <= pend_status_q;
              pix_q       <= pend_pix_q;
              pix_valid_q <= pend_pv_q;
              last_q      <= 1'b0;
              done_q      <= done_now;
            end
            pend_v_q      <= 1'b1;
            pend_status_q <= step_status;
            pend_pix_q    <= step_pix;
            pend_pv_q     <= step_pv;
          end
          if (bit_cnt_q == 3'd7) begin
            state_q <= S_END;
          end
        end
        S_END: begin
          // release the held result as last, or an empty ok result
          res_valid_q <= 1'b1;
          status_q    <= pend_v_q ? pend_status_q : hbd_pkg::STATUS_OK;
          pix_q       <= pend_v_q ? pend_pix_q : '0;
          pix_valid_q <= pend_v_q && pend_pv_q;
          last_q      <= 1'b1;
          done_q      <= done_now;
          pend_v_q    <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign pixel_value_o  = pix_q;
  assign pixel_valid_o  = pix_valid_q;
  assign last_result_o  = last_q;
  assign image_done_o   = done_q;

endmodule
